@@ rtl/core/ledser_pkg.sv @@
// Shared types, opcodes and constants of the LED string frame serializer.
package ledser_pkg;

   localparam int LED_COUNT_DEF = 8;
   localparam int WORD_W        = 32;
   localparam int BRIGHT_W      = 5;
   localparam int BYTE_W        = 8;
   localparam int OP_W          = 3;

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_COLOR  = 3'd1;
   localparam logic [OP_W-1:0] OP_BRIGHT = 3'd2;
   localparam logic [OP_W-1:0] OP_RAW    = 3'd3;
   localparam logic [OP_W-1:0] OP_SHOW   = 3'd4;

   localparam logic [BYTE_W-1:0]   HEADER_MARK  = 8'hE0;
   localparam logic [BYTE_W-1:0]   END_BYTE     = 8'hFF;
   localparam logic [BRIGHT_W-1:0] RESET_BRIGHT = 5'd7;

   // Request tdata layout, lowest bit first.
   localparam int REQ_TDATA_W = 80;
   localparam int OFS_OP      = 0;
   localparam int OFS_INDEX   = 3;
   localparam int OFS_RED     = 11;
   localparam int OFS_GREEN   = 19;
   localparam int OFS_BLUE    = 27;
   localparam int OFS_BRIGHT  = 35;
   localparam int OFS_RAW     = 43;

   // One edit of the pixel store, index already checked against the LED count.
   typedef struct packed {
      logic                valid;
      logic [OP_W-1:0]     op;
      logic [BYTE_W-1:0]   red;
      logic [BYTE_W-1:0]   green;
      logic [BYTE_W-1:0]   blue;
      logic [BRIGHT_W-1:0] bright;
      logic [WORD_W-1:0]   raw;
   } edit_type;

endpackage

@@ rtl/core/ledser_store.sv @@
// Per-LED word store with one shared address for edits and frame reads.
module ledser_store import ledser_pkg::*; #(
   parameter int LED_COUNT = LED_COUNT_DEF,
   localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  edit_type            edit,
   input  logic [BRIGHT_W-1:0] clear_bright,
   input  logic [AddrW-1:0]    addr,
   output logic [WORD_W-1:0]   word
);

   logic [WORD_W-1:0] words_ff [LED_COUNT];
   logic [WORD_W-1:0] words_in [LED_COUNT];

   assign word = words_ff[addr];

   always_comb begin
      words_in = words_ff;
      if (edit.valid) begin
         case (edit.op)
            OP_CLEAR: begin
               for (int i = 0; i < LED_COUNT; i++) begin
                  words_in[i] = {{(WORD_W-BRIGHT_W){1'b0}}, clear_bright};
               end
            end
            OP_COLOR: begin
               words_in[addr] = {edit.red, edit.green, edit.blue, 3'b000,
                                 word[BRIGHT_W-1:0]};
            end
            OP_BRIGHT: begin
               words_in[addr] = {word[WORD_W-1:BYTE_W], 3'b000, edit.bright};
            end
            OP_RAW: begin
               words_in[addr] = edit.raw;
            end
            default: begin
               words_in = words_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            words_ff[i] <= {{(WORD_W-BRIGHT_W){1'b0}}, RESET_BRIGHT};
         end
      end else begin
         words_ff <= words_in;
      end
   end

endmodule

@@ rtl/core/ledser_frame.sv @@
// Frame sequencer: 24-bit shift register that drops a byte per shift, and registered output stage.
module ledser_frame import ledser_pkg::*; #(
   parameter int LED_COUNT = LED_COUNT_DEF,
   localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic [AddrW-1:0]   rd_addr,
   input  logic [WORD_W-1:0]  rd_word,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [BYTE_W-1:0]  rsp_byte,
   output logic               rsp_last
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_PIX  = 2'd2;
   localparam logic [1:0] PH_TAIL = 2'd3;
   localparam logic [AddrW-1:0] LAST_LED = AddrW'(LED_COUNT - 1);
   localparam int SR_W = WORD_W - BYTE_W;

   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [AddrW-1:0]  led_ff, led_in;
   logic [SR_W-1:0]   sr_ff, sr_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, byte_in;
   logic              out_last_ff, last_in;
   logic              emit;

   assign busy       = (phase_ff != PH_IDLE);
   assign rd_addr    = led_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_byte   = out_byte_ff;
   assign rsp_last   = out_last_ff;
   assign emit       = busy && (!out_valid_ff || rsp_tready);

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      led_in   = led_ff;
      sr_in    = sr_ff;
      byte_in  = '0;
      last_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_HEAD;
               cnt_in   = '0;
            end
         end
         PH_HEAD: begin
            if (emit) begin
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  phase_in = PH_PIX;
                  led_in   = '0;
               end
            end
         end
         PH_PIX: begin
            if (cnt_ff == 2'd0) begin
               byte_in = HEADER_MARK | {3'b000, rd_word[BRIGHT_W-1:0]};
            end else begin
               byte_in = sr_ff[BYTE_W-1:0];
            end
            if (emit) begin
               cnt_in = cnt_ff + 2'd1;
               // Load on the header byte, then drop one byte per transfer.
               if (cnt_ff == 2'd0) begin
                  sr_in = rd_word[WORD_W-1:BYTE_W];
               end else begin
                  sr_in = {{BYTE_W{1'b0}}, sr_ff[SR_W-1:BYTE_W]};
               end
               if (cnt_ff == 2'd3) begin
                  if (led_ff == LAST_LED) begin
                     phase_in = PH_TAIL;
                  end else begin
                     led_in = led_ff + AddrW'(1);
                  end
               end
            end
         end
         PH_TAIL: begin
            byte_in = END_BYTE;
            last_in = 1'b1;
            if (emit) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         led_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         led_ff       <= led_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      if (emit) begin
         out_byte_ff <= byte_in;
         out_last_ff <= last_in;
      end
   end

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_byte_ff == END_BYTE)
      else $error("frame end flag on a byte other than the closing byte");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> phase_ff == PH_IDLE)
      else $error("show request taken while a frame is in progress");

   a_tail_done: assert property (@(posedge clock) disable iff (reset)
      emit && phase_ff == PH_TAIL |=> phase_ff == PH_IDLE && out_valid_ff && out_last_ff)
      else $error("closing byte did not end the frame");

   a_led_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIX |-> led_ff <= LAST_LED)
      else $error("LED counter beyond the string length");

endmodule

@@ rtl/core/led_string_frame_serializer.sv @@
// Top level of the LED string frame serializer: request decode, config register, store, frame.
// Edits (clear, set color, set brightness, set raw) are written to the store; a new request
// is taken in the cycle after the edit transfer. Show: the request sets the frame phase
// register, and the first byte turns valid from the output register; the byte shift register
// then gives one byte per cycle while rsp_tready is high, 4*LED_COUNT+5 bytes.
// A new request is taken once the closing byte sits in the output register.
// Reset: every LED word to brightness 7 and black, clear brightness to 7, output empty.
module led_string_frame_serializer import ledser_pkg::*; #(
   parameter int LED_COUNT = LED_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[2:0], led_index[10:3], red[18:11], green[26:19], blue[34:27],
   // brightness[39:35] (42:40 unused), raw_word[74:43], zero fill[79:75]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // frame_byte[7:0]
   output logic [BYTE_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast,
   // clear brightness register
   input  logic                   csr_wr_en,
   input  logic [BRIGHT_W-1:0]    csr_wr_data
);

   localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   logic [BRIGHT_W-1:0] clear_bright_ff;
   logic                req_xfer;
   logic [OP_W-1:0]     req_op;
   logic [BYTE_W-1:0]   req_index;
   logic                index_ok;
   logic                busy;
   logic                show_start;
   logic [AddrW-1:0]    frame_addr;
   logic [AddrW-1:0]    store_addr;
   logic [WORD_W-1:0]   store_word;
   edit_type            edit;

   // Take requests only while no frame is being generated.
   assign req_tready = !busy;
   assign req_xfer   = req_tvalid && req_tready;
   assign req_op     = req_tdata[OFS_OP +: OP_W];
   assign req_index  = req_tdata[OFS_INDEX +: BYTE_W];
   assign index_ok   = (req_index < BYTE_W'(LED_COUNT));
   assign show_start = req_xfer && (req_op == OP_SHOW);

   // Clear ignores the index; per-LED edits drop out-of-range indexes.
   always_comb begin
      edit.valid  = req_xfer && ((req_op == OP_CLEAR) ||
                    (index_ok && (req_op == OP_COLOR || req_op == OP_BRIGHT ||
                                  req_op == OP_RAW)));
      edit.op     = req_op;
      edit.red    = req_tdata[OFS_RED +: BYTE_W];
      edit.green  = req_tdata[OFS_GREEN +: BYTE_W];
      edit.blue   = req_tdata[OFS_BLUE +: BYTE_W];
      edit.bright = req_tdata[OFS_BRIGHT +: BRIGHT_W];
      edit.raw    = req_tdata[OFS_RAW +: WORD_W];
   end

   // One store address: the frame walker owns it while busy, the request otherwise.
   assign store_addr = busy ? frame_addr : req_index[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_bright_ff <= RESET_BRIGHT;
      end else if (csr_wr_en) begin
         clear_bright_ff <= csr_wr_data;
      end
   end

   ledser_store #(
      .LED_COUNT (LED_COUNT)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .edit         (edit),
      .clear_bright (clear_bright_ff),
      .addr         (store_addr),
      .word         (store_word)
   );

   ledser_frame #(
      .LED_COUNT (LED_COUNT)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .start      (show_start),
      .busy       (busy),
      .rd_addr    (frame_addr),
      .rd_word    (store_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule
